[rtl/scanline_sync_splat_decoder_macros.svh]
// ----------------------------------------------------------------------------
// Scanline sync splat decoder assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_SYNC_SPLAT_DECODER_MACROS_SVH
`define SCANLINE_SYNC_SPLAT_DECODER_MACROS_SVH

// same-cycle implication
`define SSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// Scanline sync splat decoder package
// Shared widths, register codes, types and the Gaussian weight generator.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int MAX_WIDTH          = 1024;
    localparam int TAP_RADIUS_DEF     = 2;
    localparam int DIST_FRAC_BITS_DEF = 6;

    localparam int SAMPLE_W    = 16;
    localparam int ROW_W       = 16;
    localparam int COL_W       = 10;
    localparam int CONTRIB_W   = 24;
    localparam int POS_W       = 26;
    localparam int POS_FRAC    = 16;
    localparam int CENTER_W    = 11;
    localparam int LWIDTH_W    = 11;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int WEIGHT_W    = 17;
    localparam int OUT_TDATA_W = 56;
    localparam int IN_TDATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT  = 3'd5;

    localparam logic [63:0] EXP_MINUS_ONE_Q32 = 64'd1580030169;

    typedef enum logic {
        ST_WAIT_SYNC,
        ST_WRITE
    } t_line_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sync_high;
        logic signed [SAMPLE_W-1:0] sync_low;
        logic [15:0]                samples_per_line;
        logic [LWIDTH_W-1:0]        line_width;
        logic [15:0]                position_step;
        logic [ROW_W-1:0]           line_limit;
    } t_cfg;

    typedef struct packed {
        logic [ROW_W-1:0]           row;
        logic [POS_W-1:0]           pos;
        logic [CENTER_W-1:0]        center;
        logic signed [SAMPLE_W-1:0] sample;
    } t_job;

    typedef struct packed {
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_splat;

    // exp(-2 (k/2^frac_bits)^2) in Q1.16, evaluated at elaboration only
    function automatic logic [WEIGHT_W-1:0] gauss_weight(input int k, input int frac_bits);
        logic [63:0] kk;
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] pos_sum;
        logic [63:0] neg_sum;
        logic [63:0] e;
        kk = 64'(k) * 64'(k) * 64'd2;
        y  = kk << (32 - 2 * frac_bits);
        n  = y >> 32;
        f  = y & 64'hFFFF_FFFF;
        term    = 64'd1 << 32;
        pos_sum = term;
        neg_sum = 64'd0;
        if (n >= 64'd12) begin
            return '0;
        end
        // Taylor series of exp(-f)
        for (int i = 1; i <= 16; i++) begin
            term = ((term * f) >> 32) / 64'(i);
            if ((i & 1) == 1) begin
                neg_sum = neg_sum + term;
            end else begin
                pos_sum = pos_sum + term;
            end
        end
        e = pos_sum - neg_sum;
        for (int i = 0; i < 12; i++) begin
            if (64'(i) < n) begin
                e = (e * EXP_MINUS_ONE_Q32 + (64'd1 << 31)) >> 32;
            end
        end
        return WEIGHT_W'((e + 64'd32768) >> 16);
    endfunction

endpackage

[rtl/ssd_ctrl.sv]
// ----------------------------------------------------------------------------
// Scanline sync splat decoder line control
// Sync detection, line/row bookkeeping and the column mask of each sample.
// ----------------------------------------------------------------------------
module ssd_ctrl
    import ssd_pkg::*;
#(
    parameter int TAP_RADIUS = TAP_RADIUS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_accept,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output t_job                       o_job,
    output logic [2*TAP_RADIUS:0]      o_mask,
    output logic                       o_load
);

    localparam int NUM_TAPS = 2 * TAP_RADIUS + 1;

    t_line_state                r_state;
    t_line_state                n_state;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic [15:0]                r_sil;
    logic [POS_W-1:0]           r_pos;
    logic [ROW_W-1:0]           r_row;

    logic                       w_high;
    logic                       w_rise_sync;
    logic                       w_room;
    logic                       w_splat;
    logic                       w_arm;
    logic [POS_W:0]             w_pos_rnd;
    logic [CENTER_W-1:0]        w_center;
    logic signed [12:0]         w_col [NUM_TAPS];

    assign w_high      = i_sample >= i_cfg.sync_high;
    assign w_rise_sync = (i_sample < i_cfg.sync_low) && (r_prev < i_sample);
    assign w_room      = (r_sil < i_cfg.samples_per_line) && (r_row < i_cfg.line_limit);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_WAIT_SYNC: begin
                if (i_accept && w_rise_sync) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_accept && w_high) n_state = ST_WAIT_SYNC;
            end
            default: n_state = ST_WAIT_SYNC;
        endcase
    end

    always_comb begin
        w_splat = 1'b0;
        w_arm   = 1'b0;
        case (r_state)
            ST_WAIT_SYNC: w_arm   = i_accept && w_rise_sync;
            ST_WRITE:     w_splat = i_accept && !w_high && w_room;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT_SYNC;
            r_prev  <= '0;
            r_sil   <= '0;
            r_pos   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            if (i_accept) r_prev <= i_sample;
            if (w_arm) begin
                if (r_row != '1) r_row <= r_row + 16'd1;
                r_sil <= '0;
                r_pos <= '0;
            end else if (w_splat) begin
                r_sil <= r_sil + 16'd1;
                r_pos <= r_pos + POS_W'(i_cfg.position_step);
            end
        end
    end

    // rounded center column
    assign w_pos_rnd = {1'b0, r_pos} + (POS_W+1)'(1 << (POS_FRAC - 1));
    assign w_center  = w_pos_rnd[POS_W:POS_FRAC];

    for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
        assign w_col[t]  = $signed(13'({2'b00, w_center}) + 13'(t) - 13'(TAP_RADIUS));
        assign o_mask[t] = !w_col[t][12]
                         && (w_col[t][11:0] < {1'b0, i_cfg.line_width})
                         && (w_col[t][11:0] < 12'(MAX_WIDTH));
    end

    assign o_job.row    = r_row;
    assign o_job.pos    = r_pos;
    assign o_job.center = w_center;
    assign o_job.sample = i_sample;
    assign o_load       = w_splat && (|o_mask);

endmodule

[rtl/ssd_tap.sv]
// ----------------------------------------------------------------------------
// Scanline sync splat decoder tap sequencer
// Holds one sample's job and issues its columns, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ssd_tap
    import ssd_pkg::*;
#(
    parameter int TAP_RADIUS     = TAP_RADIUS_DEF,
    parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF,
    localparam int NUM_TAPS      = 2 * TAP_RADIUS + 1,
    localparam int ROM_SIZE      = (NUM_TAPS << (DIST_FRAC_BITS - 1)) + 1,
    localparam int ROM_IDX_W     = $clog2(ROM_SIZE)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_job                 i_job,
    input  logic [NUM_TAPS-1:0]  i_mask,
    input  logic                 i_advance,
    output logic                 o_free,
    output logic                 o_busy,
    output logic                 o_valid,
    output t_splat               o_splat,
    output logic [ROM_IDX_W-1:0] o_idx
);

    localparam int TAP_W = $clog2(NUM_TAPS);

    t_job                 r_job;
    logic [NUM_TAPS-1:0]  r_mask;
    logic                 r_valid;
    t_splat               r_splat;
    logic [ROM_IDX_W-1:0] r_idx;

    logic [NUM_TAPS-1:0]  w_rest;
    logic [TAP_W-1:0]     w_pick;
    logic [CENTER_W-1:0]  w_col;
    logic [POS_W+1:0]     w_diff;
    logic [POS_W+1:0]     w_dist;
    logic [POS_W+1:0]     w_kfull;
    logic [ROM_IDX_W-1:0] w_idx;

    always_comb begin
        w_pick = '0;
        for (int t = NUM_TAPS - 1; t >= 0; t--) begin
            if (r_mask[t]) w_pick = TAP_W'(t);
        end
    end

    // drop the lowest set bit
    assign w_rest = r_mask & (r_mask - NUM_TAPS'(1));

    assign w_col  = r_job.center + CENTER_W'(w_pick) - CENTER_W'(TAP_RADIUS);
    assign w_diff = {2'b00, r_job.pos} - {1'b0, w_col, {POS_FRAC{1'b0}}};
    assign w_dist = w_diff[POS_W+1] ? (~w_diff + (POS_W+2)'(1)) : w_diff;
    assign w_kfull = (w_dist + (POS_W+2)'(1 << (15 - DIST_FRAC_BITS)))
                     >> (16 - DIST_FRAC_BITS);
    assign w_idx  = (w_kfull > (POS_W+2)'(ROM_SIZE - 1)) ? ROM_IDX_W'(ROM_SIZE - 1)
                                                          : w_kfull[ROM_IDX_W-1:0];

    assign o_busy = |r_mask;
    assign o_free = !o_busy || (i_advance && (w_rest == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_mask <= i_mask;
            end else if (i_advance && o_busy) begin
                r_mask <= w_rest;
            end
            if (i_advance) r_valid <= o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_job <= i_job;
        if (i_advance && o_busy) begin
            r_splat.row    <= r_job.row;
            r_splat.col    <= w_col[COL_W-1:0];
            r_splat.sample <= r_job.sample;
            r_splat.last   <= (w_rest == '0);
            r_idx          <= w_idx;
        end
    end

    assign o_valid = r_valid;
    assign o_splat = r_splat;
    assign o_idx   = r_idx;

endmodule

[rtl/ssd_mac.sv]
// ----------------------------------------------------------------------------
// Scanline sync splat decoder weight multiply
// Weight lookup, sample times weight with rounding, output register.
// ----------------------------------------------------------------------------
module ssd_mac
    import ssd_pkg::*;
#(
    parameter int TAP_RADIUS     = TAP_RADIUS_DEF,
    parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF,
    localparam int NUM_TAPS      = 2 * TAP_RADIUS + 1,
    localparam int ROM_SIZE      = (NUM_TAPS << (DIST_FRAC_BITS - 1)) + 1,
    localparam int ROM_IDX_W     = $clog2(ROM_SIZE)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_splat                 i_splat,
    input  logic [ROM_IDX_W-1:0]   i_idx,
    input  logic                   i_tready,
    output logic                   o_advance,
    output logic                   o_tvalid,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tlast
);

    logic [WEIGHT_W-1:0]         w_rom [ROM_SIZE];
    logic [WEIGHT_W-1:0]         w_weight;
    logic signed [33:0]          w_prod;
    logic signed [33:0]          w_sum;

    logic                        r_out_valid;
    logic [ROW_W-1:0]            r_row;
    logic [COL_W-1:0]            r_col;
    logic [CONTRIB_W-1:0]        r_contrib;
    logic                        r_last;

    for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
        assign w_rom[k] = gauss_weight(k, DIST_FRAC_BITS);
    end

    assign w_weight = w_rom[i_idx];
    assign w_prod   = 34'(i_splat.sample) * $signed({1'b0, w_weight});
    // round, then floor shift by 8 to Q1.23
    assign w_sum    = w_prod + 34'sd128;

    assign o_advance = !r_out_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_row     <= i_splat.row;
            r_col     <= i_splat.col;
            r_contrib <= w_sum[31:8];
            r_last    <= i_splat.last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {(OUT_TDATA_W - ROW_W - COL_W - CONTRIB_W)'(0), r_contrib, r_col, r_row};
    assign o_tlast  = r_last;

endmodule

[rtl/scanline_sync_splat_decoder.sv]
// ----------------------------------------------------------------------------
// Scanline sync splat decoder
// Audio samples in, Gaussian-weighted raster splats (row, col, value) out.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one Q1.15 audio sample per item. m_axis carries one splat
//  per item: row, column and Q1.23 contribution; tlast marks the final splat
//  of a sample. Registers are written through i_cfg_wr_en/index/data; the
//  user must write them only while no sample is in flight, and the block
//  does not enforce it. A sample that splats leaves up to 2*TAP_RADIUS+1
//  items (five at the default), one per cycle while the output advances;
//  the sequencer holds a sample until it has issued all its columns inside
//  the line. The first splat passes the job, tap output and multiply output
//  registers. Samples that give no splat are taken at one per cycle while
//  the sequencer holds no columns. A new sample is taken in the cycle the
//  previous one issues its last column. Reset returns all registers to their
//  defaults and the decoder to waiting for line sync with row zero. When
//  m_axis_tready is low with an item valid, it holds, the pipeline freezes
//  and s_axis_tready is low while the sequencer holds columns.
// ----------------------------------------------------------------------------
`include "scanline_sync_splat_decoder_macros.svh"

module scanline_sync_splat_decoder
    import ssd_pkg::*;
#(
    parameter int TAP_RADIUS     = TAP_RADIUS_DEF,
    parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] row, [25:16] col,
                                                   // [49:26] contribution
    output logic                   m_axis_tlast,   // last splat of the sample
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int NUM_TAPS  = 2 * TAP_RADIUS + 1;
    localparam int ROM_SIZE  = (NUM_TAPS << (DIST_FRAC_BITS - 1)) + 1;
    localparam int ROM_IDX_W = $clog2(ROM_SIZE);

    t_cfg                 r_cfg;
    logic                 w_accept;
    t_job                 w_job;
    logic [NUM_TAPS-1:0]  w_mask;
    logic                 w_job_load;
    logic                 w_advance;
    logic                 w_tap_busy;
    logic                 w_s1_valid;
    t_splat               w_s1_splat;
    logic [ROM_IDX_W-1:0] w_s1_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_high        <= 16'sd5898;
            r_cfg.sync_low         <= 16'sd1638;
            r_cfg.samples_per_line <= 16'd4000;
            r_cfg.line_width       <= 11'd512;
            r_cfg.position_step    <= 16'd8372;
            r_cfg.line_limit       <= 16'd64000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SYNC_HIGH:  r_cfg.sync_high        <= i_cfg_data;
                REG_SYNC_LOW:   r_cfg.sync_low         <= i_cfg_data;
                REG_SAMPLES:    r_cfg.samples_per_line <= i_cfg_data;
                REG_LINE_WIDTH: r_cfg.line_width       <= i_cfg_data[LWIDTH_W-1:0];
                REG_POS_STEP:   r_cfg.position_step    <= i_cfg_data;
                REG_LINE_LIMIT: r_cfg.line_limit       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    ssd_ctrl #(
        .TAP_RADIUS (TAP_RADIUS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_sample (s_axis_tdata),
        .o_job    (w_job),
        .o_mask   (w_mask),
        .o_load   (w_job_load)
    );

    ssd_tap #(
        .TAP_RADIUS     (TAP_RADIUS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_tap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_job_load),
        .i_job     (w_job),
        .i_mask    (w_mask),
        .i_advance (w_advance),
        .o_free    (s_axis_tready),
        .o_busy    (w_tap_busy),
        .o_valid   (w_s1_valid),
        .o_splat   (w_s1_splat),
        .o_idx     (w_s1_idx)
    );

    ssd_mac #(
        .TAP_RADIUS     (TAP_RADIUS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_s1_valid),
        .i_splat   (w_s1_splat),
        .i_idx     (w_s1_idx),
        .i_tready  (m_axis_tready),
        .o_advance (w_advance),
        .o_tvalid  (m_axis_tvalid),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast)
    );

    // splats only happen after a sync, so row zero never reaches the output
    `SSD_ASSERT_NOW(a_row_nonzero, m_axis_tvalid, m_axis_tdata[15:0] != 16'd0,
        "splat emitted with row zero")
    `SSD_ASSERT_NOW(a_col_in_line, m_axis_tvalid,
        ({1'b0, m_axis_tdata[25:16]} < r_cfg.line_width), "splat column outside the line")
    `SSD_ASSERT_NEXT(a_job_held, w_job_load, w_tap_busy, "loaded job lost by the sequencer")

endmodule
